// ===== rtl/sbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpg_pkg
// Shared constants and types for the seeded byte permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none
package sbpg_pkg;
  localparam int TableSize  = 256;
  localparam int MapEntries = 28;
  localparam int MapLen     = (MapEntries < 1) ? 1 : ((MapEntries > 64) ? 64 : MapEntries);
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_ADV, ST_MULA, ST_MULB, ST_FIN, ST_MOD,
    ST_RD, ST_WR, ST_ORD, ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } mul_ctrl_t;

  localparam logic [1:0] OP_A = 2'd0;
  localparam logic [1:0] OP_B = 2'd1;
endpackage
`default_nettype wire

// ===== rtl/sbpg_mul.sv =====
// ----------------------------------------------------------------------------
// sbpg_mul
// Shared 64x64 low-half multiplier: one 16x64 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sbpg_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sbpg_pkg::mul_ctrl_t ctrl,
  input  wire logic [63:0]       a,
  output logic [63:0]            p,
  output logic                   done
);
  import sbpg_pkg::*;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [63:0] mplier;
  logic [2:0]  cnt;
  logic        run;
  logic [79:0] part;

  assign part = mplier * {48'd0, mcand[15:0]};
  assign p    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        run    <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= a;
        mplier <= (ctrl.op == OP_A) ? MIX_MUL_A : MIX_MUL_B;
      end else if (run) begin
        acc    <= acc + part[63:0];
        mcand  <= {16'd0, mcand[63:16]};
        mplier <= {mplier[47:0], 16'd0};
        cnt    <= cnt + 3'd1;
        if (cnt == 3'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sbpg_mod.sv =====
// ----------------------------------------------------------------------------
// sbpg_mod
// Restoring remainder of a 64-bit value by a 9-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sbpg_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [8:0]  den,
  output logic [8:0]       rem,
  output logic             done
);
  logic [63:0] sh;
  logic [9:0]  trial;
  logic [6:0]  cnt;
  logic        run;

  assign trial = {rem, sh[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        sh  <= num;
        rem <= '0;
      end else if (run) begin
        sh <= {sh[62:0], 1'b0};
        if (trial >= {1'b0, den}) rem <= 9'(trial - {1'b0, den});
        else                      rem <= trial[8:0];
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/seeded_byte_permutation_generator.sv =====
// ----------------------------------------------------------------------------
// seeded_byte_permutation_generator
// Fisher-Yates shuffle of 0..255 keyed by a splitmix64 generator.
// ----------------------------------------------------------------------------
// Sequence: identity fill of the table, then 255 steps (an advance, two multiplies
// on the shared multiplier, a finish, a remainder, 3 reads and 2 writes on the
// table), then one beat a cycle for 28 beats; busy drops on the last beat.
// A new seed is accepted only in idle, after the last beat; the receiver cannot stall.
// Reset returns the sequencer to idle; the table is refilled for each seed.
`default_nettype none
module seeded_byte_permutation_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] seed,
  output logic             busy,
  output logic             strobe,
  output logic [5:0]       entry_index,
  output logic [7:0]       mapped_code,
  output logic             last
);
  import sbpg_pkg::*;

  state_t      state, state_next;
  logic [63:0] rng;
  logic [63:0] z;
  logic [63:0] adv_state;
  logic [63:0] mul_a;
  logic [63:0] mod_num;
  logic [8:0]  remaining;
  logic [8:0]  idx;
  logic [7:0]  pick;
  logic [7:0]  top_val;
  logic [7:0]  mem [TableSize];
  logic [7:0]  rd_data;
  logic        mem_we;
  logic [7:0]  mem_wa;
  logic [7:0]  mem_wd;
  logic [7:0]  mem_ra;
  logic [1:0]  phase;
  mul_ctrl_t   mctl;
  logic [63:0] mp;
  logic        mdone;
  logic        dstart;
  logic [8:0]  drem;
  logic        ddone;
  logic        out_pend;

  sbpg_mul u_mul (.clk, .rst, .ctrl(mctl), .a(mul_a), .p(mp), .done(mdone));
  sbpg_mod u_mod (.clk, .rst, .start(dstart), .num(mod_num), .den(remaining),
                  .rem(drem), .done(ddone));

  assign adv_state = rng + GOLDEN_STEP;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mctl       = '0;
    dstart     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = idx[7:0];
    mem_wd     = idx[7:0];
    mem_ra     = idx[7:0];
    mul_a      = z;
    mod_num    = z;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_INIT;
      ST_INIT: begin
        mem_we = 1'b1;
        if (idx == 9'd255) state_next = ST_ADV;
      end
      ST_ADV: begin
        mctl.start = 1'b1;
        mctl.op    = OP_A;
        mul_a      = adv_state ^ (adv_state >> 30);
        state_next = ST_MULA;
      end
      ST_MULA: if (mdone) begin
        state_next = ST_MULB;
      end
      ST_MULB: if (mdone) state_next = ST_FIN;
      ST_FIN: begin
        dstart     = 1'b1;
        mod_num    = z ^ (z >> 31);
        state_next = ST_MOD;
      end
      ST_MOD: if (ddone) state_next = ST_RD;
      ST_RD: begin
        mem_ra = (phase == 2'd0) ? 8'(remaining - 9'd1) : pick;
        if (phase == 2'd2) state_next = ST_WR;
      end
      ST_WR: begin
        mem_we = 1'b1;
        if (phase == 2'd0) begin
          mem_wa = 8'(remaining - 9'd1);
          mem_wd = rd_data;
        end else begin
          mem_wa = pick;
          mem_wd = top_val;
          state_next = (remaining == 9'd2) ? ST_ORD : ST_ADV;
        end
      end
      ST_ORD: state_next = ST_OUT;
      ST_OUT: if (idx == 9'(MapLen)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_MULA && mdone) begin
      mctl.start = 1'b1;
      mctl.op    = OP_B;
      mul_a      = mp ^ (mp >> 27);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      phase    <= '0;
      out_pend <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: if (start) begin
          idx       <= '0;
          rng       <= seed;
          remaining <= 9'd256;
        end
        ST_INIT: begin
          idx <= (idx == 9'd255) ? 9'd0 : idx + 9'd1;
        end
        ST_ADV: begin
          rng <= adv_state;
          z   <= adv_state ^ (adv_state >> 30);
        end
        ST_MULA: if (mdone) z <= mp ^ (mp >> 27);
        ST_MULB: if (mdone) z <= mp;
        ST_FIN: z <= z ^ (z >> 31);
        ST_MOD: if (ddone) begin
          pick  <= drem[7:0];
          phase <= '0;
        end
        ST_RD: begin
          phase <= phase + 2'd1;
          if (phase == 2'd1) top_val <= rd_data;
          if (phase == 2'd2) phase <= '0;
        end
        ST_WR: begin
          phase <= phase + 2'd1;
          if (phase != 2'd0) begin
            phase     <= '0;
            remaining <= remaining - 9'd1;
            idx       <= '0;
          end
        end
        ST_ORD: begin
          idx      <= idx + 9'd1;
          out_pend <= 1'b1;
        end
        ST_OUT: begin
          idx         <= idx + 9'd1;
          strobe      <= 1'b1;
          entry_index <= 6'(idx - 9'd1);
          mapped_code <= rd_data;
          last        <= (idx == 9'(MapLen));
          if (idx == 9'(MapLen)) out_pend <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != ST_IDLE) || out_pend;
endmodule
`default_nettype wire

// ===== rtl/sbpg_checker.sv =====
// ----------------------------------------------------------------------------
// sbpg_checker
// Port-level checks on the generator's command and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
module sbpg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [5:0] entry_index,
  input wire logic       last
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("beat while idle");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && entry_index == $past(entry_index) + 6'd1)
    else $error("index gap");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe) else $error("beat after last");
endmodule

bind seeded_byte_permutation_generator sbpg_checker u_sbpg_checker (
  .clk, .rst, .start, .busy, .strobe, .entry_index, .last);
`default_nettype wire

// ===== bench/seeded_byte_permutation_generator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seeded_byte_permutation_generator_test
// Feeds seeds to the permutation generator and checks every emitted map entry
// against a shuffle computed in the bench, including extreme and random seeds.
// ----------------------------------------------------------------------------
`default_nettype none
module seeded_byte_permutation_generator_test;
  import sbpg_pkg::*;

  typedef struct packed {
    logic [5:0] index;
    logic [7:0] code;
    logic       last;
  } map_entry_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [63:0] seed;
  logic        busy;
  logic        strobe;
  logic [5:0]  entry_index;
  logic [7:0]  mapped_code;
  logic        last;

  map_entry_t  expected_entries[$];
  int          mismatch_count;
  int          send_gap_pct;

  seeded_byte_permutation_generator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .seed        (seed),
    .busy        (busy),
    .strobe      (strobe),
    .entry_index (entry_index),
    .mapped_code (mapped_code),
    .last        (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] splitmix_out(input logic [63:0] st);
    logic [63:0] z;
    z = st;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  task automatic predict_map(input logic [63:0] key);
    logic [7:0]  perm[TableSize];
    logic [63:0] gen;
    logic [7:0]  pick;
    logic [7:0]  tmp;
    map_entry_t  e;
    for (int i = 0; i < TableSize; i++) perm[i] = i[7:0];
    gen = key;
    for (int r = TableSize; r > 1; r--) begin
      gen  = gen + GOLDEN_STEP;
      pick = 8'(splitmix_out(gen) % 64'(r));
      tmp  = perm[r - 1];
      perm[r - 1] = perm[pick];
      perm[pick]  = tmp;
    end
    for (int k = 0; k < MapLen; k++) begin
      e.index = k[5:0];
      e.code  = perm[k];
      e.last  = (k == MapLen - 1);
      expected_entries.insert(expected_entries.size(), e);
    end
  endtask

  task automatic send_seed(input logic [63:0] key);
    while ($urandom_range(99, 0) < send_gap_pct) @(posedge clk);
    predict_map(key);
    start <= 1'b1;
    seed  <= key;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    seed  <= {$urandom, $urandom};
    @(posedge clk);
  endtask

  task automatic drain_map;
    while (expected_entries.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    map_entry_t e;
    if (!rst && strobe) begin
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual idx %0d code %0d last %0b",
                 $time, entry_index, mapped_code, last);
        mismatch_count++;
      end else begin
        e = expected_entries.pop_front();
        if (entry_index !== e.index) begin
          $display("%0t: entry_index expected %0d actual %0d", $time, e.index, entry_index);
          mismatch_count++;
        end
        if (mapped_code !== e.code) begin
          $display("%0t: mapped_code expected %0d actual %0d", $time, e.code, mapped_code);
          mismatch_count++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $time, e.last, last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_extreme_seeds;
    send_seed(64'h0);
    send_seed(64'hffff_ffff_ffff_ffff);
    send_seed(64'h8000_0000_0000_0000);
    send_seed(64'h0000_0000_0000_0001);
    send_seed(64'h5555_5555_5555_5555);
    send_seed(64'haaaa_aaaa_aaaa_aaaa);
    send_seed(64'h0 - GOLDEN_STEP);
    drain_map();
  endtask

  task automatic test_random_seeds(input int count, input int gap_pct);
    send_gap_pct = gap_pct;
    for (int i = 0; i < count; i++) send_seed({$urandom, $urandom});
  endtask

  task automatic test_paused_sender;
    send_seed({$urandom, $urandom});
    drain_map();
    repeat (50) @(posedge clk);
    send_seed({$urandom, $urandom});
  endtask

  initial begin
    mismatch_count = 0;
    send_gap_pct   = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    seed  <= 64'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_seeds();
    test_random_seeds(31, 19);
    test_paused_sender();
    test_random_seeds(31, 47);
    test_random_seeds(31, 0);
    drain_map();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
